[design/cld_pkg.sv]
`timescale 1ns / 1ps

package cld_pkg;

  // Width of the length accumulator and of the body byte counter.
  localparam int LENGTH_BITS = 32;
  // Width of the body_length field on the result channel.
  localparam int OUT_LEN_W   = 32;
  localparam int KEY_LEN     = 15;
  localparam int KP_W        = 4;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_BODY    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_NO_KEY  = 2'd2,
    KIND_BAD_NUM = 2'd3
  } kind_t;

  // Progress through the number that follows the keyword.
  typedef enum logic [3:0] {
    PH_NONE   = 4'b0001,
    PH_BLANK  = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_END    = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             data_byte;
    logic [OUT_LEN_W-1:0]   body_length;
    logic                   last_of_body;
  } result_t;

  // Characters of "Content-Length:".
  function automatic logic [7:0] key_char(input logic [KP_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[design/cld_in_reg.sv]
`timescale 1ns / 1ps

module cld_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       step,
  output logic       byte_valid,
  output logic [7:0] byte_val
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // The register can take a new byte when empty or when its byte moves on now.
  assign in_tready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_val   = byte_r;

endmodule

[design/cld_parser.sv]
`timescale 1ns / 1ps

module cld_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         in_byte,
  output logic               res_valid,
  output cld_pkg::result_t   res
);

  localparam int LB = cld_pkg::LENGTH_BITS;

  logic                     in_body_r, in_body_nxt;
  logic [1:0]               term_r, term_nxt;
  logic [cld_pkg::KP_W-1:0] kp_r, kp_nxt;
  cld_pkg::phase_t          phase_r, phase_nxt;
  logic [LB-1:0]            acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [LB-1:0]            rem_r, rem_nxt;

  logic          is_digit;
  logic          is_blank;
  logic [LB+3:0] prod;
  logic          done;
  logic          key_done;

  assign is_digit = (in_byte >= cld_pkg::CH_ZERO) && (in_byte <= cld_pkg::CH_NINE);
  assign is_blank = (in_byte == cld_pkg::CH_SPACE) || (in_byte == cld_pkg::CH_TAB);
  assign key_done = (kp_r == cld_pkg::KP_W'(cld_pkg::KEY_LEN));

  // acc * 10 + digit; any of the top four bits set means the length overflows.
  assign prod = ({4'b0000, acc_r} << 3) + ({4'b0000, acc_r} << 1)
              + {{LB{1'b0}}, in_byte[3:0]};

  always_comb begin
    in_body_nxt = in_body_r;
    term_nxt    = term_r;
    kp_nxt      = kp_r;
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    rem_nxt     = rem_r;
    done        = 1'b0;
    res_valid   = 1'b0;
    res         = '{kind: cld_pkg::KIND_BODY, data_byte: 8'h00,
                    body_length: '0, last_of_body: 1'b0};

    if (in_body_r) begin
      rem_nxt       = rem_r - LB'(1);
      res_valid     = 1'b1;
      res.data_byte = in_byte;
      if (rem_r == LB'(1)) begin
        res.last_of_body = 1'b1;
        in_body_nxt      = 1'b0;
      end
    end else begin
      // Keyword match first, then the blanks and digits after it.
      if (!key_done) begin
        if (in_byte == cld_pkg::key_char(kp_r)) begin
          kp_nxt = kp_r + 1'b1;
          if (kp_r == cld_pkg::KP_W'(cld_pkg::KEY_LEN - 1)) begin
            phase_nxt = cld_pkg::PH_BLANK;
          end
        end else if (in_byte == cld_pkg::key_char('0)) begin
          kp_nxt = cld_pkg::KP_W'(1);
        end else begin
          kp_nxt = '0;
        end
      end else begin
        case (phase_r)
          cld_pkg::PH_BLANK: begin
            if (!is_blank) begin
              if (is_digit) begin
                phase_nxt = cld_pkg::PH_DIGITS;
                if (!ovf_r) begin
                  if (prod[LB+3:LB] != 4'b0000) begin
                    ovf_nxt = 1'b1;
                  end else begin
                    acc_nxt = prod[LB-1:0];
                  end
                end
              end else begin
                phase_nxt = cld_pkg::PH_NONE;
              end
            end
          end
          cld_pkg::PH_DIGITS: begin
            if (!is_digit) begin
              phase_nxt = cld_pkg::PH_END;
            end else if (!ovf_r) begin
              if (prod[LB+3:LB] != 4'b0000) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = prod[LB-1:0];
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (in_byte == cld_pkg::CH_CR) begin
        term_nxt = (term_r == 2'd2) ? 2'd3 : 2'd1;
      end else if (in_byte == cld_pkg::CH_LF) begin
        if (term_r == 2'd1) begin
          term_nxt = 2'd2;
        end else if (term_r == 2'd3) begin
          done = 1'b1;
        end else begin
          term_nxt = 2'd0;
        end
      end else begin
        term_nxt = 2'd0;
      end

      if (done) begin
        res_valid = 1'b1;
        if (kp_nxt != cld_pkg::KP_W'(cld_pkg::KEY_LEN)) begin
          res.kind = cld_pkg::KIND_NO_KEY;
        end else if (phase_nxt == cld_pkg::PH_NONE || phase_nxt == cld_pkg::PH_BLANK ||
                     ovf_nxt) begin
          res.kind = cld_pkg::KIND_BAD_NUM;
        end else begin
          res.kind        = cld_pkg::KIND_ACCEPT;
          res.body_length = cld_pkg::OUT_LEN_W'(acc_nxt);
          if (acc_nxt == '0) begin
            res.last_of_body = 1'b1;
          end else begin
            in_body_nxt = 1'b1;
            rem_nxt     = acc_nxt;
          end
        end
        term_nxt  = 2'd0;
        kp_nxt    = '0;
        phase_nxt = cld_pkg::PH_NONE;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      term_r    <= 2'd0;
      kp_r      <= '0;
      phase_r   <= cld_pkg::PH_NONE;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      rem_r     <= '0;
    end else if (step) begin
      in_body_r <= in_body_nxt;
      term_r    <= term_nxt;
      kp_r      <= kp_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      ovf_r     <= ovf_nxt;
      rem_r     <= rem_nxt;
    end
  end

endmodule

[design/cld_out_reg.sv]
`timescale 1ns / 1ps

module cld_out_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  cld_pkg::result_t                 res,
  output logic                             free,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cld_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);

  logic             valid_r, valid_nxt;
  cld_pkg::result_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.body_length, res_r.data_byte};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last_of_body;

endmodule

[design/content_length_deframer_core.sv]
`timescale 1ns / 1ps

// Splits a byte stream into headers and bodies. Each header runs up to the
// first CR LF CR LF and may carry a "Content-Length:" field with a decimal
// length after optional spaces or tabs.
// Input channel: one stream byte per transfer on in_tdata.
// Result channel: at the end of a header one transfer reports the frame as
// accepted (with its body length) or dropped for a missing keyword or a bad
// or overflowing number; after an accept exactly that many body bytes follow
// as transfers of kind zero, the last one with out_tlast set. An accept with
// zero length carries out_tlast itself. Header bytes give no transfer.
// Throughput is one byte per clock while no result waits on a stalled
// receiver: each byte passes once through the matcher and counter logic
// between the input register and the result register, and out_tvalid
// rises once the byte has passed through both registers.
// Reset empties both registers and returns the parser to header search.
// When the receiver stalls, a result waits in the result register while the
// input register still takes a byte; header bytes keep flowing since they
// produce nothing, and in_tready drops only once a byte with a result
// must wait behind the held one.
module content_length_deframer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // in_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cld_pkg::OUT_TDATA_W-1:0]  out_tdata,  // data_byte, body_length
  output logic [1:0]                       out_tuser,  // kind
  output logic                             out_tlast   // last_of_body
);

  logic             byte_valid;
  logic [7:0]       byte_val;
  logic             res_valid;
  cld_pkg::result_t res;
  logic             out_free;
  logic             step;
  logic             load;

  assign step = byte_valid && (!res_valid || out_free);
  assign load = step && res_valid;

  cld_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .step       (step),
    .byte_valid (byte_valid),
    .byte_val   (byte_val)
  );

  cld_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_byte   (byte_val),
    .res_valid (res_valid),
    .res       (res)
  );

  cld_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // Only body transfers carry a data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cld_pkg::KIND_BODY |-> out_tdata[7:0] == 8'h00)
    else $error("data byte set on a non-body transfer");

  // An accept is marked last exactly when its body is empty.
  a_accept_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == cld_pkg::KIND_ACCEPT |->
      out_tlast == (out_tdata[cld_pkg::OUT_TDATA_W-1:8] == '0))
    else $error("accept last flag does not match its length");

  // Dropped headers carry neither a length nor a last flag.
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == cld_pkg::KIND_NO_KEY || out_tuser == cld_pkg::KIND_BAD_NUM)
      |-> !out_tlast && out_tdata == '0)
    else $error("drop transfer carries payload");

  // The input side stalls only behind a held byte that has a result to deliver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> byte_valid && res_valid && out_tvalid && !out_tready)
    else $error("input stalled without a blocked result");
`endif

endmodule
